// ----- hdl/i4fp16_pkg.sv -----
// ----------------------------------------------------------------------------
// i4fp16_pkg: shared constants for the int4 to fp16 dequantizer
// Field widths and half-precision encoding constants.
// ----------------------------------------------------------------------------
`default_nettype none
package i4fp16_pkg;
  localparam int ByteW  = 8;
  localparam int HalfW  = 16;
  localparam logic [4:0]  ExpMax   = 5'h1F;
  localparam logic [15:0] InfBits  = 16'h7C00;
  localparam logic [15:0] DefNan   = 16'hFE01;
  localparam logic [15:0] QuietBit = 16'h0200;
endpackage
`default_nettype wire

// ----- hdl/i4fp16_core.sv -----
// ----------------------------------------------------------------------------
// i4fp16_core: combinational nibble-times-scale multiply and rounding
// Selects and sign-extends the nibble, forms the exact product and rounds
// it once to half precision, nearest-even, with IEEE special cases.
// ----------------------------------------------------------------------------
`default_nettype none
module i4fp16_core (
  input  wire logic [i4fp16_pkg::ByteW-1:0] packed_byte,
  input  wire logic                         high_nibble,
  input  wire logic [i4fp16_pkg::HalfW-1:0] scale_bits,
  output logic      [i4fp16_pkg::HalfW-1:0] value_fp16
);
  import i4fp16_pkg::*;

  logic [3:0]  nib;
  logic        neg;
  logic [3:0]  mag;
  logic [4:0]  sexp;
  logic [9:0]  smant;
  logic        rsign;
  logic [10:0] sig;
  logic [14:0] prod;
  logic [3:0]  top;
  logic [4:0]  ebase;
  logic [14:0] norm;
  logic [10:0] keep;
  logic [3:0]  sh;
  logic        guard, sticky;
  logic [11:0] rnd;
  logic [5:0]  bexp;

  // Product of the 11-bit significand and the 4-bit magnitude; scale
  // exponent is applied afterwards since it only shifts.
  always_comb begin
    nib    = high_nibble ? packed_byte[7:4] : packed_byte[3:0];
    neg    = nib[3];
    mag    = neg ? (4'd0 - nib) : nib;
    sexp   = scale_bits[14:10];
    smant  = scale_bits[9:0];
    rsign  = scale_bits[15] ^ neg;
    sig    = {(sexp != 5'd0), smant};
    prod   = 15'(sig) * 15'(mag);
    ebase  = (sexp == 5'd0) ? 5'd0 : sexp - 5'd1;
    // Leading-one position of the 15-bit product.
    top = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (prod[i]) top = 4'(i);
    end
    // Value is prod * 2^ebase units of 2^-24.
    sh     = (top > 4'd10) ? top - 4'd10 : 4'd0;
    norm   = prod >> sh;
    keep   = norm[10:0];
    guard  = (sh != 4'd0) ? prod[sh-4'd1] : 1'b0;
    sticky = 1'b0;
    for (int i = 0; i < 14; i++) begin
      if ((4'(i) + 4'd1 < sh) && prod[i]) sticky = 1'b1;
    end
    rnd  = {1'b0, keep} + 12'(guard && (sticky || keep[0]));
    // Biased exponent = top + ebase - 9 when the top bit lands at >= 10 overall.
    bexp = 6'(top) + 6'(ebase) + 6'(sh != 4'd0 ? 4'd0 : 4'd0);
    value_fp16 = 16'd0;
    if (sexp == ExpMax) begin
      if (smant != 10'd0) value_fp16 = scale_bits | QuietBit | 16'd1;
      else if (mag == 4'd0) value_fp16 = DefNan;
      else value_fp16 = {rsign, 15'd0} | InfBits;
    end else if (prod == 15'd0) begin
      value_fp16 = {rsign, 15'd0};
    end else if ({1'b0, top} + {1'b0, ebase} < 6'd10) begin
      // Subnormal and exact: prod << ebase fits in 10 bits.
      value_fp16 = {rsign, 5'd0, 10'(prod << ebase)};
    end else begin
      if (top < 4'd10) begin
        // Shift up to align; always exact.
        rnd  = 12'(prod << (4'd10 - top));
      end
      bexp = 6'(top) + 6'(ebase) - 6'd9 + 6'(rnd[11]);
      if (bexp >= 6'd31) value_fp16 = {rsign, 15'd0} | InfBits;
      else value_fp16 = {rsign, bexp[4:0], rnd[11] ? 10'd0 : rnd[9:0]};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/int4_to_fp16_dequantizer_top.sv -----
// ----------------------------------------------------------------------------
// int4_to_fp16_dequantizer_top: int4 symmetric dequantization to fp16
// Usage:
//   Input beats carry in_packed_byte, in_high_nibble and in_scale_bits on
//   in_valid, and are taken when in_stall is low. Each beat yields one
//   result beat on out_value_fp16 with out_valid; the receiver holds it
//   with out_stall.
//   A beat passes an input register, the multiply-and-round logic, then the
//   output register. Throughput is one beat per cycle while out_stall is low,
//   set by the combinational path between the two registers.
//   When the receiver stalls, a full output register holds its beat; the
//   input register keeps accepting until it too holds a beat, so in_stall
//   rises only when both stages are full.
//   Reset (rst_n low, synchronous) empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none
module int4_to_fp16_dequantizer_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [i4fp16_pkg::ByteW-1:0] in_packed_byte,
  input  wire logic                         in_high_nibble,
  input  wire logic [i4fp16_pkg::HalfW-1:0] in_scale_bits,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [i4fp16_pkg::HalfW-1:0] out_value_fp16
);
  import i4fp16_pkg::*;

  logic             s1_vld_r, out_vld_r;
  logic [ByteW-1:0] byte_r;
  logic             hi_r;
  logic [HalfW-1:0] scale_r, res_r, res_c;
  logic             out_free, s1_adv;

  // Stage handshake.
  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      byte_r  <= in_packed_byte;
      hi_r    <= in_high_nibble;
      scale_r <= in_scale_bits;
    end
  end

  i4fp16_core u_core (
    .packed_byte (byte_r),
    .high_nibble (hi_r),
    .scale_bits  (scale_r),
    .value_fp16  (res_c)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
    if (s1_adv) res_r <= res_c;
  end

  assign out_valid      = out_vld_r;
  assign out_value_fp16 = res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_fp16))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r)
    else $error("stall with a free stage");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("beat lost between stages");
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the int4 to fp16 dequantizer
// Drives packed nibbles with half-precision scales through a valid/stall
// channel, predicts each rounded half-precision product and checks every
// result beat in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// Holds predicted products and compares result beats against them.
class dequant_scoreboard;
  logic [15:0] pending_products[$];
  int          mismatches;
  int          checked;

  // Round a magnitude in units of 2^-24 to half precision, ties to even.
  static function logic [15:0] round_to_half(logic [15:0] sgn, logic [63:0] units);
    int          msb;
    int          sh;
    logic [31:0] biased;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] halfway;
    if (units < 64'd1024) return sgn | units[15:0];
    msb = 63;
    while (units[msb] == 1'b0) msb--;
    biased = msb - 9;
    keep = units;
    if (msb > 10) begin
      sh = msb - 10;
      rem = units & ((64'd1 << sh) - 1);
      halfway = 64'd1 << (sh - 1);
      keep = units >> sh;
      if (rem > halfway || (rem == halfway && keep[0])) begin
        keep++;
        if (keep == 64'd2048) begin
          keep = 64'd1024;
          biased++;
        end
      end
    end
    if (biased >= 31) return sgn | i4fp16_pkg::InfBits;
    return sgn | {1'b0, biased[4:0], keep[9:0]};
  endfunction

  // Work out the half-precision product for one input beat.
  static function logic [15:0] dequant_product(logic [7:0] pbyte, logic hi,
                                               logic [15:0] scale);
    logic [3:0]  code;
    logic [3:0]  mag;
    logic [15:0] rsign;
    logic [4:0]  sexp;
    logic [9:0]  smant;
    logic [63:0] units;
    code = hi ? pbyte[7:4] : pbyte[3:0];
    mag = code[3] ? 4'(5'd16 - code) : code;
    sexp = scale[14:10];
    smant = scale[9:0];
    rsign = {scale[15] ^ code[3], 15'd0};
    if (sexp == i4fp16_pkg::ExpMax) begin
      if (smant != 0) return scale | i4fp16_pkg::QuietBit | 16'd1;
      if (mag == 0) return i4fp16_pkg::DefNan;
      return rsign | i4fp16_pkg::InfBits;
    end
    if (sexp == 0) units = smant;
    else units = {53'd0, 1'b1, smant} << (sexp - 1);
    units = units * mag;
    if (units == 0) return rsign;
    return round_to_half(rsign, units);
  endfunction

  function void note_input(logic [7:0] pbyte, logic hi, logic [15:0] scale);
    pending_products.push_back(dequant_product(pbyte, hi, scale));
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    if (pending_products.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = pending_products.pop_front();
    checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("value_fp16 mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module tb;
  localparam int WatchdogLimit = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_packed_byte;
  logic        in_high_nibble;
  logic [15:0] in_scale_bits;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_value_fp16;

  dequant_scoreboard board;
  int  idle_cycles;
  int  beats_sent;
  bit  stall_quiet;

  int4_to_fp16_dequantizer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_packed_byte(in_packed_byte), .in_high_nibble(in_high_nibble),
    .in_scale_bits(in_scale_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value_fp16(out_value_fp16)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random scale with weight on the special encodings.
  function automatic logic [15:0] pick_scale();
    logic [15:0] s;
    s = 16'($urandom);
    case ($urandom_range(0, 9))
      0: s[14:10] = 5'h1F;
      1: s[14:10] = 5'h00;
      2: s[14:10] = 5'($urandom_range(27, 30));
      default: ;
    endcase
    return s;
  endfunction

  // Present one input beat and hold it until accepted. Valid stays high
  // afterwards so the next beat can follow with no gap.
  task automatic send_beat(logic [7:0] pbyte, logic hi, logic [15:0] scale,
                           bit use_gap);
    int gap;
    gap = use_gap ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_byte <= pbyte;
    in_high_nibble <= hi;
    in_scale_bits  <= scale;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(pbyte, hi, scale);
    beats_sent++;
  endtask

  // Receiver side: check accepted beats and toggle stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_value_fp16);
      if (stall_quiet) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 30) ? ($urandom_range(0, 9) < 8) : 1'b0;
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (in_valid || board.pending_products.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("int4_to_fp16_dequantizer_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] edge_scales[8];
    logic [7:0]  pb;
    int          n;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_packed_byte = '0;
    in_high_nibble = 1'b0;
    in_scale_bits = '0;
    out_stall = 1'b0;
    stall_quiet = 1'b0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: code extremes against zero, subnormal, huge, infinite and NaN
    // scales, including rounding that overflows to infinity.
    edge_scales = '{16'h0000, 16'h8001, 16'h03FF, 16'h7BFF,
                    16'h7C00, 16'hFC00, 16'h7C01, 16'hFE00};
    foreach (edge_scales[i]) begin
      send_beat(8'h80, 1'b0, edge_scales[i], 0);
      send_beat(8'h80, 1'b1, edge_scales[i], 0);
      send_beat(8'h7F, 1'b1, edge_scales[i], 0);
    end
    send_beat(8'h0F, 1'b0, 16'h3C00, 0);
    in_valid <= 1'b0;

    // Hold the sender until everything has drained.
    while (board.pending_products.size() != 0) @(posedge clk);

    // Random beats, with a quiet-receiver stretch in the middle.
    for (n = 0; n < 700; n++) begin
      stall_quiet = (n >= 300 && n < 380);
      pb = 8'($urandom);
      send_beat(pb, 1'($urandom), pick_scale(), 1);
    end
    in_valid <= 1'b0;
    stall_quiet = 1'b0;

    while (board.pending_products.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d beats, checked %0d results across signed codes and all", beats_sent,
             board.checked);
    $display("scale classes: zero, subnormal, normal, overflow, infinity and NaN.");
    if (board.mismatches == 0)
      $display("int4_to_fp16_dequantizer_top verification clean");
    else
      $display("int4_to_fp16_dequantizer_top verification failed");
    $finish;
  end
endmodule

`default_nettype wire
